// ===== src/swbm_pkg.sv =====
// ----------------------------------------------------------------------------
// swbm_pkg
// shared widths, constants and the sample record of the bandwidth meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swbm_pkg;

   // field widths
   localparam int TS_W       = 48;
   localparam int BYTES_W    = 32;
   localparam int WIN_W      = 32;
   localparam int RATE_W     = 61;

   // bits per byte times microseconds per second
   localparam int SCALE_W    = 23;
   localparam logic [SCALE_W-1:0] BITS_USEC = 23'd8000000;

   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   localparam int DEFAULT_SAMPLE_DEPTH = 64;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_METER_ENABLE = 1'b0;
   localparam logic REG_WINDOW_US    = 1'b1;
   localparam logic ENABLE_RESET     = 1'b1;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000000;

   // byte-count lanes
   localparam int LANES   = 2;
   localparam int LANE_RX = 0;
   localparam int LANE_TX = 1;

   typedef struct packed {
      logic [TS_W-1:0]    ts;
      logic [BYTES_W-1:0] rx;
      logic [BYTES_W-1:0] tx;
   } sample_type;

endpackage

// ===== src/sliding_window_bandwidth_meter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_bandwidth_meter
// rx/tx bandwidth over a sliding time window, one rate item per sample item
// ----------------------------------------------------------------------------
// usage:
//   req channel (valid/stall) carries one sample item: a microsecond
//   timestamp and the rx and tx byte counts since the previous sample.
//   rsp channel (valid/stall) returns exactly one item per sample: rx and tx
//   bits per second, the samples left in the window and a flag that tells
//   the oldest sample was pushed out by a full history.
//   the csr port holds meter_enable (address 0) and window_us (address 4).
// timing:
//   one item at a time. a full history first drops its oldest sample,
//   then the sample is inserted and each sample that ages out costs a
//   read/compare pair on the history memory; then the restoring divider
//   runs NumW = 32 + clog2(SAMPLE_DEPTH) + 23 steps, 61 at the default
//   depth. a disabled meter answers with the held rates and skips the
//   history and the divider.
// reset:
//   clears the history pointer, count, totals and held rates, enables the
//   meter with a one second window. history memory is not cleared.
// stall:
//   a finished item waits in the output register; the next sample is taken
//   meanwhile and its result waits in the sequencer until the output frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_bandwidth_meter #(
   parameter int SAMPLE_DEPTH = swbm_pkg::DEFAULT_SAMPLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [swbm_pkg::TS_W-1:0]             req_timestamp_us,
   input  logic [swbm_pkg::BYTES_W-1:0]          req_rx_bytes,
   input  logic [swbm_pkg::BYTES_W-1:0]          req_tx_bytes,
   // rate items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [swbm_pkg::RATE_W-1:0]           rsp_rx_bits_per_second,
   output logic [swbm_pkg::RATE_W-1:0]           rsp_tx_bits_per_second,
   output logic [$clog2(SAMPLE_DEPTH+1)-1:0]     rsp_samples_in_window,
   output logic                                  rsp_full_evicted,
   // configuration
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [swbm_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [swbm_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [swbm_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int PtrW   = $clog2(SAMPLE_DEPTH);
   localparam int CountW = $clog2(SAMPLE_DEPTH + 1);
   // sum of a full history of 32-bit byte counts
   localparam int TotalW = swbm_pkg::BYTES_W + PtrW;
   // total times 8e6, the dividend
   localparam int NumW   = TotalW + swbm_pkg::SCALE_W;
   localparam int StepW  = $clog2(NumW);
   localparam int WideW  = (NumW > swbm_pkg::RATE_W) ? NumW : swbm_pkg::RATE_W;
   localparam int TsW    = swbm_pkg::TS_W;
   localparam int WinW   = swbm_pkg::WIN_W;
   localparam int RateW  = swbm_pkg::RATE_W;
   localparam int Lanes  = swbm_pkg::LANES;

   // sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_FULL_DROP = 3'd1;
   localparam logic [2:0] S_INSERT    = 3'd2;
   localparam logic [2:0] S_EVICT_RD  = 3'd3;
   localparam logic [2:0] S_EVICT_CHK = 3'd4;
   localparam logic [2:0] S_MUL       = 3'd5;
   localparam logic [2:0] S_DIV       = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   logic [2:0]                 state_ff, state_in;
   logic                       enable_ff, enable_in;
   logic [WinW-1:0]            win_ff, win_in;
   swbm_pkg::sample_type       item_ff, item_in;
   logic [PtrW-1:0]            optr_ff, optr_in;
   logic [CountW-1:0]          count_ff, count_in;
   logic [TotalW-1:0]          total_ff [Lanes];
   logic [TotalW-1:0]          total_in [Lanes];
   logic [RateW-1:0]           rate_ff  [Lanes];
   logic [RateW-1:0]           rate_in  [Lanes];
   logic                       evicted_ff, evicted_in;
   logic [TsW-1:0]             start_ff, start_in;
   logic [NumW-1:0]            quot_ff  [Lanes];
   logic [NumW-1:0]            quot_in  [Lanes];
   logic [WinW-1:0]            rem_ff   [Lanes];
   logic [WinW-1:0]            rem_in   [Lanes];
   logic [StepW-1:0]           step_ff, step_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RateW-1:0]           out_rx_ff, out_rx_in;
   logic [RateW-1:0]           out_tx_ff, out_tx_in;
   logic [CountW-1:0]          out_count_ff, out_count_in;
   logic                       out_evicted_ff, out_evicted_in;

   // history memory
   swbm_pkg::sample_type       sample_mem [SAMPLE_DEPTH];
   swbm_pkg::sample_type       rd_q_ff;
   logic                       rd_en;
   logic                       mem_we;
   logic [PtrW-1:0]            slot;
   logic [PtrW:0]              slot_sum;

   logic                       accept;
   logic                       full;
   logic                       older;
   logic                       out_free;
   logic                       csr_wr;
   logic [PtrW-1:0]            optr_next;
   logic [swbm_pkg::BYTES_W-1:0] rd_bytes   [Lanes];
   logic [swbm_pkg::BYTES_W-1:0] item_bytes [Lanes];
   logic [NumW-1:0]            prod       [Lanes];
   logic [WinW:0]              rem_sh     [Lanes];
   logic                       ge         [Lanes];
   logic [WinW-1:0]            rem_next   [Lanes];
   logic [NumW-1:0]            quot_next  [Lanes];
   logic [WideW-1:0]           q_wide     [Lanes];
   logic [RateW-1:0]           rate_sat   [Lanes];

   // ------------------------------------------------------------------
   // handshakes and configuration
   // ------------------------------------------------------------------
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   // register index sits in address bit 2
   assign prdata = (paddr[2] == swbm_pkg::REG_WINDOW_US) ? win_ff
                 : {{(swbm_pkg::CSR_DATA_W-1){1'b0}}, enable_ff};

   always_comb begin
      enable_in = enable_ff;
      win_in    = win_ff;
      if (csr_wr) begin
         if (paddr[2] == swbm_pkg::REG_WINDOW_US) begin
            win_in = pwdata;
         end else begin
            enable_in = pwdata[0];
         end
      end
   end

   // ------------------------------------------------------------------
   // history addressing: oldest entry is read, newest slot is written
   // ------------------------------------------------------------------
   assign full      = (count_ff == CountW'(SAMPLE_DEPTH));
   assign optr_next = (optr_ff == PtrW'(SAMPLE_DEPTH - 1)) ? '0 : optr_ff + 1'b1;
   // count is at most depth - 1 when a sample is inserted, so the sum wraps once
   assign slot_sum  = (PtrW+1)'(optr_ff) + (PtrW+1)'(count_ff);
   assign slot      = (slot_sum >= (PtrW+1)'(SAMPLE_DEPTH))
                    ? PtrW'(slot_sum - (PtrW+1)'(SAMPLE_DEPTH)) : PtrW'(slot_sum);
   assign mem_we    = (state_ff == S_INSERT);
   assign rd_en     = (accept && enable_ff && full) || (state_ff == S_EVICT_RD);
   assign older     = (rd_q_ff.ts < start_ff);

   assign rd_bytes[swbm_pkg::LANE_RX]   = rd_q_ff.rx;
   assign rd_bytes[swbm_pkg::LANE_TX]   = rd_q_ff.tx;
   assign item_bytes[swbm_pkg::LANE_RX] = item_ff.rx;
   assign item_bytes[swbm_pkg::LANE_TX] = item_ff.tx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[slot] <= item_ff;
      end
      if (rd_en) begin
         rd_q_ff <= sample_mem[optr_ff];
      end
   end

   // ------------------------------------------------------------------
   // rate datapath: scale by 8e6, then one restoring divider per lane
   // ------------------------------------------------------------------
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         prod[l]      = NumW'(total_ff[l]) * NumW'(swbm_pkg::BITS_USEC);
         rem_sh[l]    = {rem_ff[l], quot_ff[l][NumW-1]};
         ge[l]        = (rem_sh[l] >= {1'b0, win_ff});
         rem_next[l]  = ge[l] ? WinW'(rem_sh[l] - {1'b0, win_ff}) : rem_sh[l][WinW-1:0];
         quot_next[l] = {quot_ff[l][NumW-2:0], ge[l]};
         q_wide[l]    = WideW'(quot_next[l]);
         rate_sat[l]  = (q_wide[l] > WideW'(swbm_pkg::RATE_MAX))
                      ? swbm_pkg::RATE_MAX : q_wide[l][RateW-1:0];
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      optr_in        = optr_ff;
      count_in       = count_ff;
      evicted_in     = evicted_ff;
      start_in       = start_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      out_rx_in      = out_rx_ff;
      out_tx_in      = out_tx_ff;
      out_count_in   = out_count_ff;
      out_evicted_in = out_evicted_ff;
      for (int l = 0; l < Lanes; l++) begin
         total_in[l] = total_ff[l];
         rate_in[l]  = rate_ff[l];
         quot_in[l]  = quot_ff[l];
         rem_in[l]   = rem_ff[l];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in.ts = req_timestamp_us;
               item_in.rx = req_rx_bytes;
               item_in.tx = req_tx_bytes;
               evicted_in = 1'b0;
               if (!enable_ff) begin
                  // disabled: answer with the held state
                  state_in = S_DONE;
               end else if (full) begin
                  state_in = S_FULL_DROP;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_FULL_DROP: begin
            for (int l = 0; l < Lanes; l++) begin
               total_in[l] = total_ff[l] - TotalW'(rd_bytes[l]);
            end
            optr_in    = optr_next;
            count_in   = count_ff - 1'b1;
            evicted_in = 1'b1;
            state_in   = S_INSERT;
         end
         S_INSERT: begin
            for (int l = 0; l < Lanes; l++) begin
               total_in[l] = total_ff[l] + TotalW'(item_bytes[l]);
            end
            count_in = count_ff + 1'b1;
            // window start clamps at zero early in time
            start_in = (item_ff.ts >= TsW'(win_ff)) ? item_ff.ts - TsW'(win_ff) : '0;
            state_in = S_EVICT_RD;
         end
         S_EVICT_RD: begin
            state_in = S_EVICT_CHK;
         end
         S_EVICT_CHK: begin
            if ((count_ff != '0) && older) begin
               for (int l = 0; l < Lanes; l++) begin
                  total_in[l] = total_ff[l] - TotalW'(rd_bytes[l]);
               end
               optr_in  = optr_next;
               count_in = count_ff - 1'b1;
               state_in = S_EVICT_RD;
            end else if ((count_ff != '0) && (win_ff != '0)) begin
               state_in = S_MUL;
            end else begin
               // zero window: rates hold
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            for (int l = 0; l < Lanes; l++) begin
               quot_in[l] = prod[l];
               rem_in[l]  = '0;
            end
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            for (int l = 0; l < Lanes; l++) begin
               quot_in[l] = quot_next[l];
               rem_in[l]  = rem_next[l];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(NumW - 1)) begin
               for (int l = 0; l < Lanes; l++) begin
                  rate_in[l] = rate_sat[l];
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               out_rx_in      = rate_ff[swbm_pkg::LANE_RX];
               out_tx_in      = rate_ff[swbm_pkg::LANE_TX];
               out_count_in   = count_ff;
               out_evicted_in = evicted_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= swbm_pkg::ENABLE_RESET;
         win_ff       <= swbm_pkg::WINDOW_RESET;
         optr_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < Lanes; l++) begin
            total_ff[l] <= '0;
            rate_ff[l]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         win_ff       <= win_in;
         optr_ff      <= optr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int l = 0; l < Lanes; l++) begin
            total_ff[l] <= total_in[l];
            rate_ff[l]  <= rate_in[l];
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      evicted_ff     <= evicted_in;
      start_ff       <= start_in;
      step_ff        <= step_in;
      out_rx_ff      <= out_rx_in;
      out_tx_ff      <= out_tx_in;
      out_count_ff   <= out_count_in;
      out_evicted_ff <= out_evicted_in;
      for (int l = 0; l < Lanes; l++) begin
         quot_ff[l] <= quot_in[l];
         rem_ff[l]  <= rem_in[l];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_rx_bits_per_second = out_rx_ff;
   assign rsp_tx_bits_per_second = out_tx_ff;
   assign rsp_samples_in_window  = out_count_ff;
   assign rsp_full_evicted       = out_evicted_ff;

`ifndef ASSERT_OFF
   // history never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(SAMPLE_DEPTH))
      else $error("sample count above history depth");

   // a forced drop only happens from a full history
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FULL_DROP) |-> (count_ff == CountW'(SAMPLE_DEPTH)))
      else $error("forced drop without a full history");

   // the newest sample is never aged out
   a_keep_newest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVICT_CHK && count_ff != '0 && older) |-> (count_ff > CountW'(1)))
      else $error("eviction would empty the history");

   // a finished item reaches the output register
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not presented");

   // divider runs only with a nonzero window
   a_div_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (win_ff != '0))
      else $error("division by a zero window");
`endif

endmodule

// ===== tb/sliding_window_bandwidth_meter_test.sv =====
// ----------------------------------------------------------------------------
// sliding_window_bandwidth_meter_test
// self-checking bench: sample items in, bandwidth items out, csr reconfigured
// between phases
// ----------------------------------------------------------------------------
// a clocked driver offers sample items from a queue that the stimulus process
// fills, and it predicts the rate item of every accepted sample with a local
// copy of the history, totals and held rates. a clocked monitor stalls at
// random, takes rate items and compares them field by field with the oldest
// prediction. csr writes happen only with nothing in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_bandwidth_meter_test;

   localparam int DEPTH = swbm_pkg::DEFAULT_SAMPLE_DEPTH;
   localparam logic [swbm_pkg::TS_W-1:0] TS_MAX = '1;
   localparam int RANDOM_ITEMS = 600;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 250;
   localparam int MAX_PRINTED = 100;

   // how timestamps advance inside a run of samples
   typedef enum int {PACE_HOLD, PACE_FINE, PACE_COARSE, PACE_NOISE} pace_type;

   // one predicted rate item
   typedef struct packed {
      logic [swbm_pkg::RATE_W-1:0] rx_rate;
      logic [swbm_pkg::RATE_W-1:0] tx_rate;
      logic [6:0]                  held;
      logic                        evicted;
   } rate_item_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // block ports, all known from time zero
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [swbm_pkg::TS_W-1:0]         req_timestamp_us = '0;
   logic [swbm_pkg::BYTES_W-1:0]      req_rx_bytes = '0;
   logic [swbm_pkg::BYTES_W-1:0]      req_tx_bytes = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [swbm_pkg::RATE_W-1:0]       rsp_rx_bits_per_second;
   logic [swbm_pkg::RATE_W-1:0]       rsp_tx_bits_per_second;
   logic [6:0]                        rsp_samples_in_window;
   logic                              rsp_full_evicted;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [swbm_pkg::CSR_ADDR_W-1:0]   paddr = '0;
   logic [swbm_pkg::CSR_DATA_W-1:0]   pwdata = '0;
   logic [swbm_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   sliding_window_bandwidth_meter dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_timestamp_us       (req_timestamp_us),
      .req_rx_bytes           (req_rx_bytes),
      .req_tx_bytes           (req_tx_bytes),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_rx_bits_per_second (rsp_rx_bits_per_second),
      .rsp_tx_bits_per_second (rsp_tx_bits_per_second),
      .rsp_samples_in_window  (rsp_samples_in_window),
      .rsp_full_evicted       (rsp_full_evicted),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   // ---------------------------------------------------------------------
   // predictor state: sample history ring, totals, held rates, csr copy
   // ---------------------------------------------------------------------
   swbm_pkg::sample_type          history [DEPTH];
   int unsigned                   oldest_idx;
   int unsigned                   held_count;
   logic [63:0]                   rx_sum;
   logic [63:0]                   tx_sum;
   logic [swbm_pkg::RATE_W-1:0]   rx_rate_held;
   logic [swbm_pkg::RATE_W-1:0]   tx_rate_held;
   logic                          meter_on;
   logic [swbm_pkg::WIN_W-1:0]    window_len;

   // bench bookkeeping
   swbm_pkg::sample_type  pending_samples [$];
   rate_item_type         expected_rates [$];
   int                    mismatch_count = 0;
   bit                    steady_sender = 1'b0;
   int                    long_hold_asked = 0;
   int                    long_hold_taken = 0;
   logic [swbm_pkg::TS_W-1:0] now_us = '0;

   // floor(total * 8e6 / win), saturated to the rate width
   function automatic logic [swbm_pkg::RATE_W-1:0] bits_per_second(
         logic [63:0] total, logic [swbm_pkg::WIN_W-1:0] win);
      logic [127:0] scaled;
      scaled = 128'(total) * 128'(swbm_pkg::BITS_USEC);
      scaled = scaled / 128'(win);
      if (scaled > 128'(swbm_pkg::RATE_MAX))
         return swbm_pkg::RATE_MAX;
      return scaled[swbm_pkg::RATE_W-1:0];
   endfunction

   function automatic void drop_oldest_sample();
      rx_sum -= 64'(history[oldest_idx].rx);
      tx_sum -= 64'(history[oldest_idx].tx);
      oldest_idx = (oldest_idx + 1) % DEPTH;
      held_count--;
   endfunction

   // advance the predictor by one accepted sample, return its rate item
   function automatic rate_item_type predict_rates(swbm_pkg::sample_type s);
      rate_item_type r;
      logic [63:0]   start;
      int unsigned   slot;
      r.evicted = 1'b0;
      if (meter_on) begin
         // full history: oldest sample leaves before the new one goes in
         if (held_count >= DEPTH) begin
            drop_oldest_sample();
            r.evicted = 1'b1;
         end
         slot = (oldest_idx + held_count) % DEPTH;
         history[slot] = s;
         held_count++;
         rx_sum += 64'(s.rx);
         tx_sum += 64'(s.tx);
         // window start clamps at zero for early timestamps
         start = (64'(s.ts) >= 64'(window_len)) ? 64'(s.ts) - 64'(window_len) : 64'd0;
         while (held_count > 0 && 64'(history[oldest_idx].ts) < start)
            drop_oldest_sample();
         // zero window or empty history keeps the held rates
         if (held_count > 0 && window_len != '0) begin
            rx_rate_held = bits_per_second(rx_sum, window_len);
            tx_rate_held = bits_per_second(tx_sum, window_len);
         end
      end
      r.rx_rate = rx_rate_held;
      r.tx_rate = tx_rate_held;
      r.held    = 7'(held_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // sample driver: offers queued items, predicts on every accepted one
   // ---------------------------------------------------------------------
   swbm_pkg::sample_type offered;
   int                   gap_left = 0;
   bit                   sender_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rates.push_back(predict_rates(offered));
         // a stalled item holds still, otherwise pick what comes next
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               offered = pending_samples.pop_front();
               req_timestamp_us <= offered.ts;
               req_rx_bytes     <= offered.rx;
               req_tx_bytes     <= offered.tx;
               req_valid        <= 1'b1;
               // switch between idling and back-to-back stretches now and then
               if ($urandom_range(0, 39) == 0)
                  sender_calm = !sender_calm;
               gap_left = (steady_sender || sender_calm) ? 0 : $urandom_range(0, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // rate monitor: random stall, one long hold on request, field checks
   // ---------------------------------------------------------------------
   rate_item_type want;
   int            stall_left = 0;
   bit            receiver_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rates.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_samples_in_window), 64'd0);
            end else begin
               want = expected_rates.pop_front();
               if (rsp_rx_bits_per_second !== want.rx_rate)
                  report_mismatch("rx_bits_per_second", 64'(rsp_rx_bits_per_second),
                                  64'(want.rx_rate));
               if (rsp_tx_bits_per_second !== want.tx_rate)
                  report_mismatch("tx_bits_per_second", 64'(rsp_tx_bits_per_second),
                                  64'(want.tx_rate));
               if (rsp_samples_in_window !== want.held)
                  report_mismatch("samples_in_window", 64'(rsp_samples_in_window),
                                  64'(want.held));
               if (rsp_full_evicted !== want.evicted)
                  report_mismatch("full_evicted", 64'(rsp_full_evicted), 64'(want.evicted));
            end
            if ($urandom_range(0, 39) == 0)
               receiver_calm = !receiver_calm;
            stall_left = receiver_calm ? 0 : $urandom_range(0, 5);
         end
         // long hold so the block backs up and stalls its input
         if (long_hold_taken != long_hold_asked) begin
            long_hold_taken++;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_sample(logic [swbm_pkg::TS_W-1:0] ts,
                               logic [swbm_pkg::BYTES_W-1:0] rx,
                               logic [swbm_pkg::BYTES_W-1:0] tx);
      swbm_pkg::sample_type s;
      s.ts = ts;
      s.rx = rx;
      s.tx = tx;
      pending_samples.push_back(s);
   endtask

   function automatic logic [swbm_pkg::BYTES_W-1:0] byte_count();
      return ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1500);
   endfunction

   // settled view taken at the falling edge, so nothing is mid-update
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_rates.size() != 0);
   endtask

   // csr write with a setup and an access phase; the register takes the value at the access edge
   task automatic csr_write(logic reg_index, logic [swbm_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_index == swbm_pkg::REG_METER_ENABLE)
         meter_on = value[0];
      else
         window_len = value;
   endtask

   // registers change only with nothing in flight
   task automatic reconfigure(logic reg_index, logic [swbm_pkg::CSR_DATA_W-1:0] value);
      wait_idle();
      csr_write(reg_index, value);
   endtask

   // a run of samples; some noise items jump anywhere in time
   task automatic queue_run(int count, pace_type pace);
      logic [63:0] step;
      logic [63:0] next_us;
      for (int i = 0; i < count; i++) begin
         step = 64'd0;
         if (pace == PACE_NOISE || $urandom_range(0, 9) == 0) begin
            now_us = swbm_pkg::TS_W'({$urandom, $urandom});
         end else begin
            case (pace)
               PACE_HOLD:   step = 64'($urandom_range(0, 1));
               PACE_FINE:   step = 64'($urandom_range(0, window_len / 48));
               default:     step = 64'($urandom_range(0, window_len)) *
                                   64'($urandom_range(0, 2));
            endcase
            next_us = 64'(now_us) + step;
            // wrap back near zero rather than overflow the timestamp
            now_us = (next_us > 64'(TS_MAX)) ? swbm_pkg::TS_W'($urandom_range(0, 1000))
                                             : next_us[swbm_pkg::TS_W-1:0];
         end
         queue_sample(now_us, byte_count(), byte_count());
      end
   endtask

   function automatic logic [swbm_pkg::WIN_W-1:0] pick_window();
      case ($urandom_range(0, 7))
         0:       return 32'd1;
         1:       return 32'($urandom_range(2, 1000));
         2, 3:    return swbm_pkg::WINDOW_RESET;
         4:       return $urandom;
         5:       return '1;
         6:       return 32'($urandom_range(1000, 100000));
         default: return '0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int        counted;
      int        run_len;
      pace_type  pace;
      logic      enable_bit;

      oldest_idx   = 0;
      held_count   = 0;
      rx_sum       = '0;
      tx_sum       = '0;
      rx_rate_held = '0;
      tx_rate_held = '0;
      meter_on     = swbm_pkg::ENABLE_RESET;
      window_len   = swbm_pkg::WINDOW_RESET;
      counted      = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset config, all-zero sample at time zero
      queue_sample('0, '0, '0);
      queue_sample(48'd5, '1, '1);
      queue_sample(48'd1000, 32'd1, '0);
      // everything before one second ages out
      queue_sample(48'd2000000, 32'd123, 32'd456);
      // time going backwards, early time keeps the window start at zero
      queue_sample(48'd100, 32'd7, 32'd9);
      queue_sample(TS_MAX, '1, '0);

      // widest window
      reconfigure(swbm_pkg::REG_WINDOW_US, '1);
      queue_sample(TS_MAX, '0, '1);
      queue_sample(48'hFFFF_0000_0000, 32'd1, 32'd2);
      queue_sample(TS_MAX, '1, '1);

      // narrowest window
      reconfigure(swbm_pkg::REG_WINDOW_US, 32'd1);
      queue_sample(48'd1000, 32'd10, 32'd20);
      queue_sample(48'd1000, 32'd30, 32'd40);
      queue_sample(48'd1001, '1, 32'd1);
      queue_sample(48'd1003, 32'd5, '1);

      // zero window: eviction runs, rates hold
      reconfigure(swbm_pkg::REG_WINDOW_US, '0);
      queue_sample(48'd1003, 32'd11, 32'd12);
      queue_sample(48'd1003, 32'd13, 32'd14);
      queue_sample(48'd1010, 32'd15, 32'd16);

      // disabled meter ignores samples and repeats held values
      reconfigure(swbm_pkg::REG_METER_ENABLE, 1'b0);
      queue_sample(48'd5000, '1, '1);
      queue_sample('0, 32'd3, 32'd4);
      reconfigure(swbm_pkg::REG_METER_ENABLE, 1'b1);
      reconfigure(swbm_pkg::REG_WINDOW_US, swbm_pkg::WINDOW_RESET);

      // back-pressure: receiver holds off while the sender keeps going, with
      // samples packed closely in time but for the occasional random jump
      wait_idle();
      steady_sender = 1'b1;
      long_hold_asked++;
      now_us = 48'd10000000;
      queue_run(80, PACE_HOLD);
      wait_idle();
      steady_sender = 1'b0;

      // random phases, each with its own window and enable
      while (counted < RANDOM_ITEMS) begin
         enable_bit = ($urandom_range(0, 7) != 0);
         reconfigure(swbm_pkg::REG_WINDOW_US, pick_window());
         reconfigure(swbm_pkg::REG_METER_ENABLE, enable_bit);
         case ($urandom_range(0, 9))
            0, 1, 2: pace = PACE_HOLD;
            3, 4, 5: pace = PACE_FINE;
            6, 7, 8: pace = PACE_COARSE;
            default: pace = PACE_NOISE;
         endcase
         run_len = $urandom_range(20, 90);
         queue_run(run_len, pace);
         counted += run_len;
      end

      // drain, let the pipeline settle, then judge
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rates.size() == 0) begin
         $display("** sliding_window_bandwidth_meter: PASSED **");
      end else begin
         $display("** sliding_window_bandwidth_meter: FAILED **");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #2000000;
      $display("** sliding_window_bandwidth_meter: FAILED **");
      $finish;
   end

endmodule

// ===== sliding_window_bandwidth_meter.f =====
src/swbm_pkg.sv
src/sliding_window_bandwidth_meter.sv
tb/sliding_window_bandwidth_meter_test.sv
